[design/wpf_pkg.sv]
// shared types, constants and route table for the waypoint pid follower
`default_nettype none
package wpf_pkg;

  localparam int NUM_WAYPOINTS_DEF = 8;
  localparam int FRAC_BITS_DEF     = 12;

  localparam longint PI_Q28 = 64'sd843314857;

  // register indexes on the config port
  localparam logic [2:0] REG_PROP  = 3'd0;
  localparam logic [2:0] REG_DERIV = 3'd1;
  localparam logic [2:0] REG_INTEG = 3'd2;
  localparam logic [2:0] REG_DTOL  = 3'd3;
  localparam logic [2:0] REG_ATOL  = 3'd4;

  // widths sized for the largest fraction setting
  localparam int EW  = 19;  // pid error and error difference operands
  localparam int IW  = 32;  // integrals
  localparam int GW  = 32;  // gains
  localparam int CW  = 16;  // commands
  localparam int GAIN_SHIFT = 24;

  localparam logic [16:0] LAST_DIST_RST = 17'd8192;

  typedef struct packed {
    logic x_on;
    logic y_on;
    logic signed [2:0] quad;   // goal heading in multiples of pi/2
  } wpf_route_t;

  typedef struct packed {
    logic p;
    logic d;
    logic i;
  } wpf_gbits_t;

  typedef struct packed {
    logic clear;
    logic step;
  } wpf_mac_ctl_t;

  function automatic wpf_route_t wpf_route(input logic [2:0] idx);
    wpf_route_t r;
    case (idx)
      3'd0:    r = '{x_on: 1'b1, y_on: 1'b0, quad: 3'sd0};
      3'd1:    r = '{x_on: 1'b1, y_on: 1'b0, quad: 3'sd1};
      3'd2:    r = '{x_on: 1'b1, y_on: 1'b1, quad: 3'sd1};
      3'd3:    r = '{x_on: 1'b1, y_on: 1'b1, quad: 3'sd2};
      3'd4:    r = '{x_on: 1'b0, y_on: 1'b1, quad: 3'sd2};
      3'd5:    r = '{x_on: 1'b0, y_on: 1'b1, quad: 3'sd3};
      3'd6:    r = '{x_on: 1'b0, y_on: 1'b0, quad: -3'sd1};
      default: r = '{x_on: 1'b0, y_on: 1'b0, quad: 3'sd0};
    endcase
    return r;
  endfunction

  // mag * pi/2 in the given fraction, rounded half up
  function automatic longint half_pi_q(input longint mag, input int frac);
    longint q;
    q = (mag * PI_Q28 + (64'sd1 <<< (28 - frac))) >>> (29 - frac);
    return q;
  endfunction

endpackage
`default_nettype wire

[design/wpf_serial_mac.sv]
// bit-serial pid sum: one gain bit per cycle while step is high, over all three products
`default_nettype none
module wpf_serial_mac (
  input  wire logic                           clk,
  input  wire wpf_pkg::wpf_mac_ctl_t          ctl,
  input  wire wpf_pkg::wpf_gbits_t            gbits,
  input  wire logic signed [wpf_pkg::EW-1:0]  err,
  input  wire logic signed [wpf_pkg::EW-1:0]  diff,
  input  wire logic signed [wpf_pkg::IW-1:0]  integ,
  output logic signed [wpf_pkg::CW-1:0]       cmd
);

  localparam int TW  = 34;
  localparam int ACW = 35;
  localparam int LW  = wpf_pkg::GW;
  localparam int FW  = ACW + LW - wpf_pkg::GAIN_SHIFT;

  logic signed [ACW-1:0] acc_r, acc_nxt;
  logic [LW-1:0]         low_r, low_nxt;
  logic signed [TW-1:0]  term;
  logic signed [ACW-1:0] sum;
  logic signed [FW-1:0]  full;

  always_comb begin
    term = '0;
    if (gbits.p) term = term + {{(TW-wpf_pkg::EW){err[wpf_pkg::EW-1]}}, err};
    if (gbits.d) term = term + {{(TW-wpf_pkg::EW){diff[wpf_pkg::EW-1]}}, diff};
    if (gbits.i) term = term + {{(TW-wpf_pkg::IW){integ[wpf_pkg::IW-1]}}, integ};
    sum     = acc_r + {{(ACW-TW){term[TW-1]}}, term};
    acc_nxt = {sum[ACW-1], sum[ACW-1:1]};
    low_nxt = {sum[0], low_r[LW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
      low_r <= '0;
    end else if (ctl.step) begin
      acc_r <= acc_nxt;
      low_r <= low_nxt;
    end
  end

  // floor of the product sum over 2^24, then saturate
  always_comb begin
    full = {acc_r, low_r[LW-1:wpf_pkg::GAIN_SHIFT]};
    if (full > FW'(32767))
      cmd = 16'sd32767;
    else if (full < -FW'(32768))
      cmd = -16'sd32768;
    else
      cmd = full[wpf_pkg::CW-1:0];
  end

endmodule
`default_nettype wire

[design/waypoint_pid_follower_unit.sv]
// top level of the waypoint pid follower
// One pose transaction gives one command transaction. After the accepting edge
// the block runs the bit-serial sum of squares of the position error, the
// bit-per-cycle square root, a load of the pid operands, the two bit-serial
// pid sums (one gain bit per cycle) and a write-back into the result register.
// The next pose can be taken once the result is written. The block holds one
// pose at a time; in_stall is high while a pose is in work. A finished result
// sits in the output register, and the next pose may be taken while it waits;
// the next result is written only as that one leaves or once it has left.
// Configuration writes are always ready and should be made while idle.
`default_nettype none
module waypoint_pid_follower_unit #(
  parameter int NUM_WAYPOINTS = wpf_pkg::NUM_WAYPOINTS_DEF,
  parameter int FRAC_BITS     = wpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_pose_x,
  input  wire logic signed [15:0] in_pose_y,
  input  wire logic signed [14:0] in_pose_heading,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_linear_cmd,
  output logic signed [15:0]      out_angular_cmd,
  output logic [2:0]              out_waypoint_now,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int EW = wpf_pkg::EW;
  localparam int IW = wpf_pkg::IW;

  // goal constants for this fraction setting
  localparam logic signed [18:0] XGOAL = 19'(2 << FRAC_BITS);
  localparam logic signed [20:0] HP1 = 21'(wpf_pkg::half_pi_q(1, FRAC_BITS));
  localparam logic signed [20:0] HP2 = 21'(wpf_pkg::half_pi_q(2, FRAC_BITS));
  localparam logic signed [20:0] HP3 = 21'(wpf_pkg::half_pi_q(3, FRAC_BITS));
  localparam logic [2:0] LAST_WP = 3'(NUM_WAYPOINTS - 1);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_ROOT, S_LOAD, S_PID, S_DONE} state_t;

  state_t state_r;
  logic [4:0] cnt_r;

  // configuration registers
  logic [31:0] prop_gain_r, deriv_gain_r, integ_gain_r;
  logic [14:0] dist_tol_r, angle_tol_r;

  // controller state
  logic [2:0]          wp_r;
  logic [16:0]         last_d_r;
  logic signed [16:0]  last_h_r;
  logic signed [IW-1:0] integ_d_r, integ_h_r;

  // per-pose working registers
  logic [17:0]         dxm_r, dym_r, dxs_r, dys_r;
  logic [18:0]         sq_acc_r;
  logic [17:0]         sq_low_r;
  logic [37:0]         rad_r;
  logic [19:0]         rem_r;
  logic [18:0]         root_r;
  logic [16:0]         ed_r;
  logic signed [16:0]  et_r;
  logic signed [EW-1:0] dd_r, dh_r;
  logic [31:0]         pgs_r, dgs_r, igs_r;

  logic out_valid_r;
  logic signed [15:0] lin_r, ang_r;
  logic [2:0] wp_out_r;

  // input side combinational: route lookup, position and heading errors
  wpf_pkg::wpf_route_t rt;
  logic signed [18:0] dx, dy, ndx, ndy;
  logic signed [20:0] goal, eth;
  logic signed [16:0] et_clamp;
  logic in_fire;

  always_comb begin
    rt  = wpf_pkg::wpf_route(wp_r);
    dx  = (rt.x_on ? XGOAL : 19'sd0) - {{3{in_pose_x[15]}}, in_pose_x};
    dy  = (rt.y_on ? XGOAL : 19'sd0) - {{3{in_pose_y[15]}}, in_pose_y};
    ndx = -dx;
    ndy = -dy;
    case (rt.quad)
      3'sd1:   goal = HP1;
      3'sd2:   goal = HP2;
      3'sd3:   goal = (wp_r == 3'd5 && in_pose_heading[14]) ? -HP1 : HP3;
      -3'sd1:  goal = -HP1;
      default: goal = 21'sd0;
    endcase
    eth = goal - {{6{in_pose_heading[14]}}, in_pose_heading};
    if (eth > 21'sd65535)
      et_clamp = 17'sd65535;
    else if (eth < -21'sd65536)
      et_clamp = -17'sd65536;
    else
      et_clamp = eth[16:0];
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // serial sum of squares: one multiplier bit of each axis per cycle
  logic [18:0] sq_term;
  logic [19:0] sq_sum;
  always_comb begin
    sq_term = (dxs_r[0] ? {1'b0, dxm_r} : 19'd0) + (dys_r[0] ? {1'b0, dym_r} : 19'd0);
    sq_sum  = {1'b0, sq_acc_r} + {1'b0, sq_term};
  end

  // square root: one result bit per cycle
  logic [21:0] rem2, trial, rem_sub;
  logic        ge;
  always_comb begin
    rem2    = {rem_r, rad_r[37:36]};
    trial   = {1'b0, root_r, 2'b01};
    ge      = rem2 >= trial;
    rem_sub = rem2 - trial;
  end

  // pid operand preparation
  logic [16:0]         ed_new;
  logic signed [EW-1:0] dd_new, dh_new;
  logic signed [32:0]  isum_d, isum_h;
  logic signed [IW-1:0] integ_d_new, integ_h_new;

  function automatic logic signed [IW-1:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647)
      return 32'sh7fffffff;
    else if (v < -33'sd2147483648)
      return 32'sh80000000;
    else
      return v[IW-1:0];
  endfunction

  always_comb begin
    ed_new = root_r[18:17] != 2'b00 ? 17'h1ffff : root_r[16:0];
    dd_new = $signed({2'b00, ed_new}) - $signed({2'b00, last_d_r});
    dh_new = {{2{et_r[16]}}, et_r} - {{2{last_h_r[16]}}, last_h_r};
    isum_d = {integ_d_r[IW-1], integ_d_r} + $signed({16'd0, last_d_r});
    isum_h = {integ_h_r[IW-1], integ_h_r} + {{16{last_h_r[16]}}, last_h_r};
    integ_d_new = sat32(isum_d);
    integ_h_new = sat32(isum_h);
  end

  // two pid sums share the gain bit stream
  wpf_pkg::wpf_mac_ctl_t mac_ctl;
  wpf_pkg::wpf_gbits_t   gbits;
  logic signed [15:0]    lin_cmd, ang_cmd;

  assign mac_ctl.clear = (state_r == S_LOAD);
  assign mac_ctl.step  = (state_r == S_PID);
  assign gbits.p = pgs_r[0];
  assign gbits.d = dgs_r[0];
  assign gbits.i = igs_r[0];

  wpf_serial_mac u_mac_lin (
    .clk   (clk),
    .ctl   (mac_ctl),
    .gbits (gbits),
    .err   ($signed({2'b00, ed_r})),
    .diff  (dd_r),
    .integ (integ_d_r),
    .cmd   (lin_cmd)
  );

  wpf_serial_mac u_mac_ang (
    .clk   (clk),
    .ctl   (mac_ctl),
    .gbits (gbits),
    .err   ({{2{et_r[16]}}, et_r}),
    .diff  (dh_r),
    .integ (integ_h_r),
    .cmd   (ang_cmd)
  );

  // advance check: position goals on even indexes, heading goals on odd
  logic [16:0] et_abs;
  logic        reached;
  logic [2:0]  wp_next;
  always_comb begin
    et_abs  = et_r[16] ? 17'(-et_r) : et_r;
    reached = wp_r[0] ? (et_abs < {2'b00, angle_tol_r}) : (ed_r < {2'b00, dist_tol_r});
    wp_next = (wp_r == LAST_WP) ? 3'd0 : wp_r + 3'd1;
  end

  logic done_fire;
  assign done_fire = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // state, controller state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      wp_r         <= '0;
      last_d_r     <= wpf_pkg::LAST_DIST_RST;
      last_h_r     <= '0;
      integ_d_r    <= '0;
      integ_h_r    <= '0;
      prop_gain_r  <= 32'd40265318;
      deriv_gain_r <= 32'd117440512;
      integ_gain_r <= 32'd168;
      dist_tol_r   <= 15'd41;
      angle_tol_r  <= 15'd4;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          wpf_pkg::REG_PROP:  prop_gain_r  <= cfg_data;
          wpf_pkg::REG_DERIV: deriv_gain_r <= cfg_data;
          wpf_pkg::REG_INTEG: integ_gain_r <= cfg_data;
          wpf_pkg::REG_DTOL:  dist_tol_r   <= cfg_data[14:0];
          wpf_pkg::REG_ATOL:  angle_tol_r  <= cfg_data[14:0];
          default: ;
        endcase
      end

      // a new result replaces one that leaves in the same cycle
      if (done_fire)
        out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)
        out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_SQ;
            cnt_r   <= '0;
          end
        end
        S_SQ: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd17) begin
            state_r <= S_ROOT;
            cnt_r   <= '0;
          end
        end
        S_ROOT: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd18) state_r <= S_LOAD;
        end
        S_LOAD: begin
          state_r   <= S_PID;
          cnt_r     <= '0;
          integ_d_r <= integ_d_new;
          integ_h_r <= integ_h_new;
        end
        S_PID: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            state_r     <= S_IDLE;
            lin_r       <= lin_cmd;
            ang_r       <= ang_cmd;
            last_d_r    <= ed_r;
            last_h_r    <= et_r;
            if (reached) begin
              wp_r      <= wp_next;
              wp_out_r  <= wp_next;
              integ_d_r <= '0;
              integ_h_r <= '0;
            end else begin
              wp_out_r  <= wp_r;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          dxm_r    <= dx[18] ? ndx[17:0] : dx[17:0];
          dym_r    <= dy[18] ? ndy[17:0] : dy[17:0];
          dxs_r    <= dx[18] ? ndx[17:0] : dx[17:0];
          dys_r    <= dy[18] ? ndy[17:0] : dy[17:0];
          sq_acc_r <= '0;
          sq_low_r <= '0;
          et_r     <= et_clamp;
        end
      end
      S_SQ: begin
        dxs_r    <= dxs_r >> 1;
        dys_r    <= dys_r >> 1;
        sq_acc_r <= sq_sum[19:1];
        sq_low_r <= {sq_sum[0], sq_low_r[17:1]};
        if (cnt_r == 5'd17) begin
          rad_r  <= {1'b0, sq_sum[19:1], sq_sum[0], sq_low_r[17:1]};
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      S_ROOT: begin
        rad_r  <= {rad_r[35:0], 2'b00};
        rem_r  <= ge ? rem_sub[19:0] : rem2[19:0];
        root_r <= {root_r[17:0], ge};
      end
      S_LOAD: begin
        ed_r  <= ed_new;
        dd_r  <= dd_new;
        dh_r  <= dh_new;
        pgs_r <= prop_gain_r;
        dgs_r <= deriv_gain_r;
        igs_r <= integ_gain_r;
      end
      S_PID: begin
        pgs_r <= pgs_r >> 1;
        dgs_r <= dgs_r >> 1;
        igs_r <= igs_r >> 1;
      end
      default: ;
    endcase
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_linear_cmd   = lin_r;
  assign out_angular_cmd  = ang_r;
  assign out_waypoint_now = wp_out_r;

endmodule
`default_nettype wire
